// ===== rtl/lbc_pkg.sv =====
`timescale 1ns / 1ps

package lbc_pkg;

  localparam int FracBits = 16;
  localparam int ColW     = 32;
  localparam int AlphaW   = 17;

  // stream word layout
  localparam int InBits      = 6 * ColW + 2 * AlphaW;
  localparam int InDataW     = ((InBits + 7) / 8) * 8;
  localparam int OutBits     = 3 * ColW + AlphaW;
  localparam int OutDataW    = ((OutBits + 7) / 8) * 8;
  localparam int OffBaseA    = 3 * ColW;
  localparam int OffLayer    = 3 * ColW + AlphaW;
  localparam int OffLayerA   = 6 * ColW + AlphaW;
  localparam int OffOutA     = 3 * ColW;

  // datapath widths
  localparam int ProdW  = 2 * (ColW + 1);
  localparam int RndW   = ProdW - FracBits + 2;
  localparam int BlendW = RndW + 2;
  localparam int PremW  = ColW + 2;
  localparam int NumW   = ColW + FracBits + 2;
  localparam int RemW   = NumW + 1;
  localparam int QuoW   = ColW + 1;
  localparam int SatW   = 72;

  localparam logic [AlphaW-1:0] One  = AlphaW'(2 ** FracBits);
  localparam logic [AlphaW-1:0] Half = AlphaW'(2 ** (FracBits - 1));
  localparam logic signed [AlphaW:0] OneS  = $signed({1'b0, One});
  localparam logic signed [AlphaW:0] HalfS = $signed({1'b0, Half});

  localparam int CfgAddrW = 2;

  typedef enum logic [CfgAddrW-1:0] {
    CfgBlendMode    = 2'd0,
    CfgLayerOpacity = 2'd1,
    CfgScalarImage  = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ModeNormal   = 4'd0,
    ModeMultiply = 4'd1,
    ModeAdd      = 4'd2,
    ModeSubtract = 4'd3,
    ModeScreen   = 4'd4,
    ModeOverlay  = 4'd5,
    ModeMin      = 4'd6,
    ModeMax      = 4'd7,
    ModeDiff     = 4'd8,
    ModeMix      = 4'd9
  } blend_mode_e;

  typedef enum logic [2:0] {
    KindNone   = 3'd0,
    KindMul    = 3'd1,
    KindScreen = 3'd2,
    KindOvLo   = 3'd3,
    KindOvHi   = 3'd4
  } mul_kind_e;

  function automatic logic [AlphaW-1:0] clamp_unit(input logic [AlphaW-1:0] a);
    return (a > One) ? One : a;
  endfunction

  function automatic logic signed [ColW-1:0] sat_col(input logic signed [SatW-1:0] v);
    logic fits;
    fits = (&v[SatW-1:ColW-1]) || ~(|v[SatW-1:ColW-1]);
    if (fits) return v[ColW-1:0];
    else if (v[SatW-1]) return {1'b1, {(ColW - 1){1'b0}}};
    else return {1'b0, {(ColW - 1){1'b1}}};
  endfunction

endpackage

// ===== rtl/layer_blend_composite_top.sv =====
`timescale 1ns / 1ps

// layer over base pixel compositing with blend modes
// s_axis carries one base and one layer pixel per word, m_axis one composited
// pixel per word. both sides handshake on tvalid and tready.
// cfg_we_i/cfg_addr_i/cfg_wdata_i write blend_mode (0), layer_opacity (1) and
// scalar_image (2); write only while no pixel is in flight.
// the accepting edge loads the first of six arithmetic stages (blend
// products, weights, weighted sums), then one stage that takes magnitudes and
// the rounding offset, 33 restoring divider stages (one quotient bit each) and
// the output register follow on the way to m_axis_tvalid.
// throughput is one pixel per cycle while the receiver does not stall; the
// divider is fully pipelined.
// when the receiver stalls, a finished pixel waits in the output register and
// the pipeline still moves one more word into a skid register; s_axis_tready
// then drops until the output drains. s_axis_tready is registered.
// reset empties the pipeline and loads mode normal, opacity one, scalar off.
module layer_blend_composite_top import lbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // base_red, base_green, base_blue, base_alpha, layer_red, layer_green,
  // layer_blue, layer_alpha
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [AlphaW-1:0]   cfg_wdata_i
);

  localparam int PipeDepth = 6 + QuoW + 1;

  logic [3:0]        mode_q;
  logic [AlphaW-1:0] opacity_q;
  logic              scalar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeNormal;
      opacity_q <= One;
      scalar_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CfgBlendMode:    mode_q    <= cfg_wdata_i[3:0];
        CfgLayerOpacity: opacity_q <= cfg_wdata_i;
        CfgScalarImage:  scalar_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [AlphaW-1:0]        op;
  logic signed [AlphaW:0]   op_s;
  logic signed [AlphaW:0]   inv_op_s;
  logic                     mix_sel;

  assign op       = clamp_unit(opacity_q);
  assign op_s     = $signed({1'b0, op});
  assign inv_op_s = OneS - op_s;
  assign mix_sel  = !scalar_q && (mode_q == ModeMix);

  // pipeline control
  logic                 en;
  logic [PipeDepth-1:0] vld_q;
  logic                 out_v_q, skid_v_q;
  logic                 take;

  assign en            = !skid_v_q;
  assign s_axis_tready = en;
  assign take          = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeDepth-2:0], s_axis_tvalid};
    end
  end

  // shared alpha path
  logic [AlphaW-1:0]     aa1_q, la1_q, aa2_q, la2_q, aa3_q, ab3_q;
  logic [2*AlphaW-1:0]   ab_prod2_q, anum3_q;
  logic [AlphaW-1:0]     w1_4_q, w2_4_q, w3_4_q, am4_q, ao4_q, am5_q, ao5_q;
  logic                  scal6_q;
  logic [AlphaW-1:0]     alpha6_q;
  logic [AlphaW-1:0]     dalpha_q [QuoW+1];
  logic                  dscal_q  [QuoW+1];

  logic [2*AlphaW-1:0] ab_prod_d, ab_rnd, anum_d;
  logic [2*AlphaW-1:0] w1p, w2p, w3p, amp;
  logic [AlphaW-1:0]   ab_d, w1_d, w2_d, w3_d, am_d;

  always_comb begin
    ab_prod_d = (2*AlphaW)'(la1_q) * (2*AlphaW)'(op);
    ab_rnd    = ab_prod2_q + (2*AlphaW)'(Half);
    ab_d      = ab_rnd[FracBits +: AlphaW];
    anum_d    = (2*AlphaW)'(aa2_q) * (2*AlphaW)'(One - op)
              + (2*AlphaW)'(la2_q) * (2*AlphaW)'(op);
    w1p       = (2*AlphaW)'(One - ab3_q) * (2*AlphaW)'(aa3_q) + (2*AlphaW)'(Half);
    w2p       = (2*AlphaW)'(One - aa3_q) * (2*AlphaW)'(ab3_q) + (2*AlphaW)'(Half);
    w3p       = (2*AlphaW)'(aa3_q) * (2*AlphaW)'(ab3_q) + (2*AlphaW)'(Half);
    amp       = anum3_q + (2*AlphaW)'(Half);
    w1_d      = w1p[FracBits +: AlphaW];
    w2_d      = w2p[FracBits +: AlphaW];
    w3_d      = w3p[FracBits +: AlphaW];
    am_d      = amp[FracBits +: AlphaW];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      aa1_q      <= clamp_unit(s_axis_tdata[OffBaseA +: AlphaW]);
      la1_q      <= clamp_unit(s_axis_tdata[OffLayerA +: AlphaW]);
      aa2_q      <= aa1_q;
      la2_q      <= la1_q;
      ab_prod2_q <= ab_prod_d;
      aa3_q      <= aa2_q;
      ab3_q      <= ab_d;
      anum3_q    <= anum_d;
      w1_4_q     <= w1_d;
      w2_4_q     <= w2_d;
      w3_4_q     <= w3_d;
      am4_q      <= am_d;
      ao4_q      <= ab3_q + w1_d;
      am5_q      <= am4_q;
      ao5_q      <= ao4_q;
      scal6_q    <= scalar_q;
      alpha6_q   <= scalar_q ? One : (mix_sel ? am5_q : ao5_q);
      dalpha_q[0] <= alpha6_q;
      dscal_q[0]  <= scal6_q;
      for (int k = 1; k <= QuoW; k++) begin
        dalpha_q[k] <= dalpha_q[k-1];
        dscal_q[k]  <= dscal_q[k-1];
      end
    end
  end

  logic [3*ColW-1:0] fin_col;
  logic              fin_dz;

  assign fin_dz = (dalpha_q[QuoW] == '0);

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic signed [ColW-1:0]   x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q, x5_q;
    logic signed [ColW:0]     opa2_q, opb2_q;
    logic signed [ColW-1:0]   simple2_q, simple3_q, bl4_q;
    mul_kind_e                kind2_q, kind3_q;
    logic signed [NumW-1:0]   pa_prod2_q, pb_prod2_q;
    logic signed [ProdW-1:0]  prod3_q;
    logic signed [PremW-1:0]  pa3_q, pb3_q;
    logic signed [PremW+AlphaW:0] mp1_4_q, mp2_4_q;
    logic signed [NumW-1:0]   t1_5_q, t2_5_q, t3_5_q, mixnum5_q;
    logic signed [NumW:0]     sprod5_q;
    logic signed [NumW-1:0]   num6_q;
    logic signed [ColW-1:0]   sres6_q;

    // stage 1 to 2: simple blends, multiplier operands and premultiply products
    logic signed [ColW:0]   xe, ye, simple_w, opa_d, opb_d;
    logic signed [ColW-1:0] simple_d;
    mul_kind_e              kind_d;
    logic signed [NumW-1:0] pa_prod_d, pb_prod_d;

    always_comb begin
      xe       = (ColW+1)'(x1_q);
      ye       = (ColW+1)'(y1_q);
      simple_w = ye;
      kind_d   = KindNone;
      opa_d    = xe;
      opb_d    = ye;
      case (blend_mode_e'(mode_q))
        ModeMultiply: kind_d = KindMul;
        ModeAdd:      simple_w = xe + ye;
        ModeSubtract: simple_w = xe - ye;
        ModeScreen: begin
          kind_d = KindScreen;
          opa_d  = (ColW+1)'(OneS) - xe;
          opb_d  = (ColW+1)'(OneS) - ye;
        end
        ModeOverlay: begin
          if (x1_q <= HalfS) begin
            kind_d = KindOvLo;
          end else begin
            kind_d = KindOvHi;
            opa_d  = (ColW+1)'(OneS) - xe;
            opb_d  = (ColW+1)'(OneS) - ye;
          end
        end
        ModeMin:  simple_w = (xe < ye) ? xe : ye;
        ModeMax:  simple_w = (xe > ye) ? xe : ye;
        ModeDiff: simple_w = (xe > ye) ? (xe - ye) : (ye - xe);
        default:  simple_w = ye;
      endcase
      simple_d  = sat_col(SatW'(simple_w));
      pa_prod_d = NumW'(x1_q) * NumW'($signed({1'b0, aa1_q}));
      pb_prod_d = NumW'(y1_q) * NumW'($signed({1'b0, la1_q}));
    end

    // stage 2 to 3: blend product, premultiplied colour
    logic signed [ProdW-1:0] prod_d;
    logic signed [NumW-1:0]  pa_r, pb_r;

    always_comb begin
      prod_d = ProdW'(opa2_q) * ProdW'(opb2_q);
      pa_r   = (pa_prod2_q + NumW'(HalfS)) >>> FracBits;
      pb_r   = (pb_prod2_q + NumW'(HalfS)) >>> FracBits;
    end

    // stage 3 to 4: finish blend term, mix weighting
    logic signed [ProdW-1:0]  rf;
    logic signed [RndW-1:0]   r;
    logic signed [BlendW-1:0] bw;
    logic signed [ColW-1:0]   bl_d;
    logic signed [PremW+AlphaW:0] mp1_d, mp2_d;

    always_comb begin
      rf = (prod3_q + ProdW'(HalfS)) >>> FracBits;
      r  = rf[RndW-1:0];
      case (kind3_q)
        KindMul:    bw = BlendW'(r);
        KindScreen: bw = BlendW'(OneS) - BlendW'(r);
        KindOvLo:   bw = BlendW'(r) + BlendW'(r);
        KindOvHi:   bw = BlendW'(OneS) - BlendW'(r) - BlendW'(r);
        default:    bw = BlendW'(simple3_q);
      endcase
      bl_d  = sat_col(SatW'(bw));
      mp1_d = (PremW+AlphaW+1)'(pa3_q) * (PremW+AlphaW+1)'(inv_op_s);
      mp2_d = (PremW+AlphaW+1)'(pb3_q) * (PremW+AlphaW+1)'(op_s);
    end

    // stage 4 to 5: weighted products
    logic signed [NumW-1:0]      t1_d, t2_d, t3_d;
    logic signed [NumW:0]        sprod_d;
    logic signed [PremW+AlphaW+1:0] mixsum;

    always_comb begin
      t1_d    = NumW'($signed({1'b0, w1_4_q})) * NumW'(x4_q);
      t2_d    = NumW'($signed({1'b0, w2_4_q})) * NumW'(y4_q);
      t3_d    = NumW'($signed({1'b0, w3_4_q})) * NumW'(bl4_q);
      sprod_d = ((NumW+1)'(bl4_q) - (NumW+1)'(x4_q)) * (NumW+1)'(op_s);
      mixsum  = (PremW+AlphaW+2)'(mp1_4_q) + (PremW+AlphaW+2)'(mp2_4_q);
    end

    // stage 5 to 6: sums, scalar result, path select
    logic signed [NumW+1:0] ovsum;
    logic signed [NumW:0]   srnd;
    logic signed [NumW+1:0] sval;
    logic signed [NumW-1:0] num_d;

    always_comb begin
      ovsum = (NumW+2)'(t1_5_q) + (NumW+2)'(t2_5_q) + (NumW+2)'(t3_5_q);
      srnd  = (sprod5_q + (NumW+1)'(HalfS)) >>> FracBits;
      sval  = (NumW+2)'(x5_q) + (NumW+2)'(srnd);
      if (scalar_q)     num_d = '0;
      else if (mix_sel) num_d = mixnum5_q;
      else              num_d = ovsum[NumW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        x1_q       <= s_axis_tdata[c*ColW +: ColW];
        y1_q       <= s_axis_tdata[OffLayer + c*ColW +: ColW];
        x2_q       <= x1_q;
        y2_q       <= y1_q;
        opa2_q     <= opa_d;
        opb2_q     <= opb_d;
        simple2_q  <= simple_d;
        kind2_q    <= kind_d;
        pa_prod2_q <= pa_prod_d;
        pb_prod2_q <= pb_prod_d;
        x3_q       <= x2_q;
        y3_q       <= y2_q;
        prod3_q    <= prod_d;
        simple3_q  <= simple2_q;
        kind3_q    <= kind2_q;
        pa3_q      <= pa_r[PremW-1:0];
        pb3_q      <= pb_r[PremW-1:0];
        x4_q       <= x3_q;
        y4_q       <= y3_q;
        bl4_q      <= bl_d;
        mp1_4_q    <= mp1_d;
        mp2_4_q    <= mp2_d;
        x5_q       <= x4_q;
        t1_5_q     <= t1_d;
        t2_5_q     <= t2_d;
        t3_5_q     <= t3_d;
        sprod5_q   <= sprod_d;
        mixnum5_q  <= mixsum[NumW-1:0];
        num6_q     <= num_d;
        sres6_q    <= sat_col(SatW'(sval));
      end
    end

    // divider: magnitude plus half divisor, then one quotient bit per stage
    logic [RemW-1:0] rem_d [QuoW+1];
    logic [RemW-1:0] rem_q [QuoW+1];
    logic [QuoW-1:0] quo_d [QuoW+1];
    logic [QuoW-1:0] quo_q [QuoW+1];
    logic            neg_q [QuoW+1];
    logic            ovf_q [QuoW+1];
    logic signed [ColW-1:0] sres_q [QuoW+1];

    logic            neg0, ovf0;
    logic [NumW-1:0] mag0;

    always_comb begin
      neg0     = num6_q[NumW-1];
      mag0     = neg0 ? (~num6_q + NumW'(1)) : num6_q;
      rem_d[0] = RemW'(mag0) + RemW'(alpha6_q >> 1);
      quo_d[0] = '0;
      ovf0     = rem_d[0] >= (RemW'(alpha6_q) << QuoW);
    end

    for (genvar k = 1; k <= QuoW; k++) begin : g_div
      logic [RemW-1:0] sh;
      logic            ge;
      always_comb begin
        sh       = RemW'(dalpha_q[k-1]) << (QuoW - k);
        ge       = rem_q[k-1] >= sh;
        rem_d[k] = ge ? (rem_q[k-1] - sh) : rem_q[k-1];
        quo_d[k] = quo_q[k-1];
        quo_d[k][QuoW-k] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[0]  <= neg0;
        ovf_q[0]  <= ovf0;
        sres_q[0] <= sres6_q;
        for (int k = 0; k <= QuoW; k++) begin
          rem_q[k] <= rem_d[k];
          quo_q[k] <= quo_d[k];
        end
        for (int k = 1; k <= QuoW; k++) begin
          neg_q[k]  <= neg_q[k-1];
          ovf_q[k]  <= ovf_q[k-1];
          sres_q[k] <= sres_q[k-1];
        end
      end
    end

    logic signed [QuoW+1:0] qe, qs;
    logic signed [ColW-1:0] res;

    always_comb begin
      qe = $signed({2'b00, quo_q[QuoW]});
      qs = neg_q[QuoW] ? -qe : qe;
      if (dscal_q[QuoW])    res = sres_q[QuoW];
      else if (fin_dz)      res = '0;
      else if (ovf_q[QuoW]) res = neg_q[QuoW] ? {1'b1, {(ColW - 1){1'b0}}}
                                              : {1'b0, {(ColW - 1){1'b1}}};
      else                  res = sat_col(SatW'(qs));
    end

    assign fin_col[c*ColW +: ColW] = res;
  end

  // output register with skid
  logic [OutDataW-1:0] fin_data;
  logic [OutDataW-1:0] out_data_q, skid_data_q;

  assign fin_data = {{(OutDataW - OutBits){1'b0}}, dalpha_q[QuoW], fin_col};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) skid_v_q <= 1'b0;
    end else if (!out_v_q || take) begin
      out_v_q <= vld_q[PipeDepth-1];
    end else if (vld_q[PipeDepth-1]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) out_data_q <= skid_data_q;
    end else if (!out_v_q || take) begin
      out_data_q <= fin_data;
    end else begin
      skid_data_q <= fin_data;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/lbc_chk.sv =====
`timescale 1ns / 1ps

module lbc_chk import lbc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // input back-pressure only follows an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

  // result alpha stays within one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OffOutA +: AlphaW] <= One)
    else $error("output alpha above one");

  // transparent result carries no colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[OffOutA +: AlphaW] == '0)
      |-> m_axis_tdata[OffOutA-1:0] == '0)
    else $error("colour on zero alpha");

endmodule

bind layer_blend_composite_top lbc_chk u_lbc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
